@@ sv/dpa_pkg.sv @@
// ----------------------------------------------------------------------------
// dpa_pkg
// Shared constants, codes and types of the demodulator path allocator.
// ----------------------------------------------------------------------------
package dpa_pkg;

  localparam int PATHS       = 8;
  localparam int IDX_W       = (PATHS > 1) ? $clog2(PATHS) : 1;
  localparam int CNT_W       = $clog2(PATHS + 1);
  localparam int TAG_W       = 16;
  localparam int PWR_W       = 10;
  localparam int SF_W        = 4;
  localparam int DB_W        = 4;
  localparam int ACT_W       = 2;
  localparam int NUM_SENS    = 6;
  localparam int AP_W        = 4;
  localparam int REG_IDX_W   = 3;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  localparam logic [ACT_W-1:0] ACT_START_RX = 2'd0;
  localparam logic [ACT_W-1:0] ACT_END_RX   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_START_TX = 2'd2;
  localparam logic [ACT_W-1:0] ACT_TX_DONE  = 2'd3;

  localparam logic [3:0] ST_LOCKED     = 4'd0;
  localparam logic [3:0] ST_DROP_TX    = 4'd1;
  localparam logic [3:0] ST_DROP_SENS  = 4'd2;
  localparam logic [3:0] ST_DROP_NOPTH = 4'd3;
  localparam logic [3:0] ST_RX_OK      = 4'd4;
  localparam logic [3:0] ST_INTERFERED = 4'd5;
  localparam logic [3:0] ST_TX_STARTED = 4'd6;
  localparam logic [3:0] ST_TX_DONE    = 4'd7;

  localparam logic [REG_IDX_W-1:0] REG_SENS_SF7     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SENS_SF8     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SENS_SF9     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SENS_SF10    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SENS_SF11    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SENS_SF12    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_ACTIVE_PATHS = 3'd6;

  localparam logic [NUM_SENS-1:0][PWR_W-1:0] SENS_RST =
    '{-10'sd279, -10'sd273, -10'sd268, -10'sd263, -10'sd258, -10'sd253};
  localparam logic [AP_W-1:0] ACTIVE_PATHS_RST = 4'd8;

  localparam logic [SF_W-1:0] SF_MIN = 4'd7;
  localparam logic [SF_W-1:0] SF_MAX = 4'd12;

  typedef struct packed {
    logic [NUM_SENS-1:0][PWR_W-1:0] sens;
    logic [AP_W-1:0]                active_paths;
  } dpa_cfg_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } dpa_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] busy_total;
    logic [CNT_W-1:0] busy_pop;
    logic             tx_mode;
  } dpa_stat_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } dpa_state_t;

  function automatic logic [2:0] sens_sel(input logic [SF_W-1:0] sf);
    logic [2:0] s;
    if (sf < SF_MIN) begin
      s = 3'd0;
    end else if (sf > SF_MAX) begin
      s = 3'(NUM_SENS - 1);
    end else begin
      s = 3'(sf - SF_MIN);
    end
    return s;
  endfunction

endpackage

@@ sv/demodulator_path_allocator_top.sv @@
// ----------------------------------------------------------------------------
// demodulator_path_allocator_top
// Receive demodulator path pool with sensitivity gating and transmit abort.
// ----------------------------------------------------------------------------
// Each item is captured, then executed: all paths are matched in parallel
// and the pool is updated. Execution waits while the output register holds
// an untaken result. The result sits in that register, so the next item is
// taken while it waits. Writing active_paths frees every path.
module demodulator_path_allocator_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // action[1:0], event_tag[17:2], rx_power[27:18], spreading_factor[31:28],
  // destroyed_by[35:32], zero fill above.
  input  logic [dpa_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // status[3:0], path_index[6:4], path_found[7], occupied_count[11:8],
  // aborted_count[15:12], transmitting[16], zero fill above.
  output logic [dpa_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [dpa_pkg::ADDR_W-1:0]      cfg_paddr,
  input  logic [dpa_pkg::DATA_W-1:0]      cfg_pwdata,
  output logic [dpa_pkg::DATA_W-1:0]      cfg_prdata,
  output logic                            cfg_pready
);
  import dpa_pkg::*;

  dpa_cfg_t  cfg;
  dpa_cmd_t  cmd;
  dpa_stat_t stat;
  logic      clear_pool;

  dpa_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .cfg        (cfg),
    .clear_pool (clear_pool)
  );

  dpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cmd       (cmd)
  );

  dpa_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .clear_pool(clear_pool),
    .cfg       (cfg),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata),
    .stat      (stat)
  );

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    stat.busy_total == stat.busy_pop)
    else $error("busy count differs from busy paths");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("item accepted while another is in work");

  a_lock_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[3:0] == ST_LOCKED) |-> out_tdata[7])
    else $error("locked result without a path");

  a_tx_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[3:0] == ST_TX_STARTED) |->
      (out_tdata[11:8] == 4'd0 && out_tdata[16]))
    else $error("transmit start left paths busy");

endmodule

@@ sv/dpa_regs.sv @@
// ----------------------------------------------------------------------------
// dpa_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module dpa_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [dpa_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [dpa_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [dpa_pkg::DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready,
  output dpa_pkg::dpa_cfg_t          cfg,
  output logic                       clear_pool
);
  import dpa_pkg::*;

  logic [NUM_SENS-1:0][PWR_W-1:0] sens_r, sens_nxt;
  logic [AP_W-1:0]                active_r, active_nxt;
  logic [REG_IDX_W-1:0]           idx;
  logic                           wr;

  assign cfg_pready = 1'b1;
  assign idx        = cfg_paddr[ADDR_W-1:2];
  assign wr         = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign clear_pool = wr && (idx == REG_ACTIVE_PATHS);

  always_comb begin
    sens_nxt   = sens_r;
    active_nxt = active_r;
    if (wr) begin
      if (idx <= REG_SENS_SF12) begin
        sens_nxt[idx] = cfg_pwdata[PWR_W-1:0];
      end else if (idx == REG_ACTIVE_PATHS) begin
        active_nxt = cfg_pwdata[AP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_r   <= SENS_RST;
      active_r <= ACTIVE_PATHS_RST;
    end else begin
      sens_r   <= sens_nxt;
      active_r <= active_nxt;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (idx <= REG_SENS_SF12) begin
      cfg_prdata = {{(DATA_W-PWR_W){sens_r[idx][PWR_W-1]}}, sens_r[idx]};
    end else if (idx == REG_ACTIVE_PATHS) begin
      cfg_prdata = {{(DATA_W-AP_W){1'b0}}, active_r};
    end
  end

  assign cfg.sens         = sens_r;
  assign cfg.active_paths = active_r;

endmodule

@@ sv/dpa_ctrl.sv @@
// ----------------------------------------------------------------------------
// dpa_ctrl
// Controller: item capture, execution step and output valid handling.
// ----------------------------------------------------------------------------
module dpa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output dpa_pkg::dpa_cmd_t cmd
);
  import dpa_pkg::*;

  dpa_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign in_tready   = (state_r == S_IDLE);
  assign out_tvalid  = out_valid_r;
  assign slot_free   = !out_valid_r || out_tready;
  assign cmd.capture = in_tvalid && in_tready;
  assign cmd.execute = (state_r == S_EXEC) && slot_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.capture) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.execute) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.execute) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ sv/dpa_dpath.sv @@
// ----------------------------------------------------------------------------
// dpa_dpath
// Datapath: path pool, tag match, sensitivity test and result register.
// ----------------------------------------------------------------------------
module dpa_dpath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dpa_pkg::dpa_cmd_t               cmd,
  input  logic                            clear_pool,
  input  dpa_pkg::dpa_cfg_t               cfg,
  input  logic [dpa_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic [dpa_pkg::OUT_TDATA_W-1:0] out_tdata,
  output dpa_pkg::dpa_stat_t              stat
);
  import dpa_pkg::*;

  logic [ACT_W-1:0]        act_r;
  logic [TAG_W-1:0]        tag_r;
  logic signed [PWR_W-1:0] pwr_r;
  logic [SF_W-1:0]         sf_r;
  logic [DB_W-1:0]         db_r;

  logic [PATHS-1:0]        busy_r, busy_nxt;
  logic [TAG_W-1:0]        ptag_r [PATHS];
  logic                    tx_r, tx_nxt;
  logic [CNT_W-1:0]        total_r, total_nxt;

  logic [PATHS-1:0]        act_mask, free_v, match_v;
  logic [IDX_W-1:0]        free_idx, match_idx, idx;
  logic                    free_any, match_any, lock, found;
  logic [3:0]              status;
  logic [CNT_W-1:0]        aborted;
  logic signed [PWR_W-1:0] thr;

  logic [3:0]              o_status_r, o_occ_r, o_abort_r;
  logic [2:0]              o_idx_r;
  logic                    o_found_r, o_tx_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= in_tdata[1:0];
      tag_r <= in_tdata[17:2];
      pwr_r <= in_tdata[27:18];
      sf_r  <= in_tdata[31:28];
      db_r  <= in_tdata[35:32];
    end
  end

  always_comb begin
    for (int i = 0; i < PATHS; i++) begin
      act_mask[i] = (i < int'(cfg.active_paths));
      free_v[i]   = act_mask[i] && !busy_r[i];
      match_v[i]  = act_mask[i] && busy_r[i] && (ptag_r[i] == tag_r);
    end
    free_idx  = '0;
    match_idx = '0;
    for (int i = PATHS - 1; i >= 0; i--) begin
      if (free_v[i]) begin
        free_idx = IDX_W'(i);
      end
      if (match_v[i]) begin
        match_idx = IDX_W'(i);
      end
    end
    free_any  = |free_v;
    match_any = |match_v;
  end

  assign thr = $signed(cfg.sens[sens_sel(sf_r)]);

  always_comb begin
    busy_nxt  = busy_r;
    tx_nxt    = tx_r;
    total_nxt = total_r;
    aborted   = '0;
    idx       = '0;
    found     = 1'b0;
    lock      = 1'b0;
    status    = ST_DROP_TX;
    unique case (act_r)
      ACT_START_RX: begin
        if (tx_r) begin
          status = ST_DROP_TX;
        end else if (!free_any) begin
          status = ST_DROP_NOPTH;
        end else if (pwr_r < thr) begin
          status = ST_DROP_SENS;
        end else begin
          status             = ST_LOCKED;
          lock               = 1'b1;
          found              = 1'b1;
          idx                = free_idx;
          busy_nxt[free_idx] = 1'b1;
          total_nxt          = total_r + 1'b1;
        end
      end
      ACT_END_RX: begin
        status = (db_r != '0) ? ST_INTERFERED : ST_RX_OK;
        if (match_any) begin
          found               = 1'b1;
          idx                 = match_idx;
          busy_nxt[match_idx] = 1'b0;
          if (total_r != '0) begin
            total_nxt = total_r - 1'b1;
          end
        end
      end
      ACT_START_TX: begin
        status    = ST_TX_STARTED;
        aborted   = CNT_W'($countones(busy_r));
        busy_nxt  = '0;
        total_nxt = '0;
        tx_nxt    = 1'b1;
      end
      ACT_TX_DONE: begin
        status = ST_TX_DONE;
        tx_nxt = 1'b0;
      end
      default: status = ST_DROP_TX;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= '0;
      tx_r    <= 1'b0;
      total_r <= '0;
    end else if (clear_pool) begin
      busy_r  <= '0;
      total_r <= '0;
    end else if (cmd.execute) begin
      busy_r  <= busy_nxt;
      tx_r    <= tx_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute && lock) begin
      ptag_r[free_idx] <= tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      o_status_r <= status;
      o_idx_r    <= 3'(idx);
      o_found_r  <= found;
      o_occ_r    <= 4'(total_nxt);
      o_abort_r  <= 4'(aborted);
      o_tx_r     <= tx_nxt;
    end
  end

  assign out_tdata = {7'd0, o_tx_r, o_abort_r, o_occ_r, o_found_r, o_idx_r, o_status_r};

  assign stat.busy_total = total_r;
  assign stat.busy_pop   = CNT_W'($countones(busy_r));
  assign stat.tx_mode    = tx_r;

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the demodulator path allocator. Request items
// are fed from a backlog queue by a driver on the falling clock edge. A
// monitor on the rising edge predicts every accepted item with a local copy
// of the path pool and compares each result with the oldest prediction.
// Both sides idle at random. The receiver holds off once for a long stretch.
// The thresholds and the active path count are reprogrammed between phases.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dpa_pkg::*;

  localparam int PERIOD   = 10;
  localparam int LIMIT    = 200000;
  localparam int SETTLE   = 8;
  localparam int HOLD_AT  = 250;
  localparam int HOLD_LEN = 400;

  typedef struct packed {
    logic [DB_W-1:0]  destroyed;
    logic [SF_W-1:0]  sf;
    logic [PWR_W-1:0] power;
    logic [TAG_W-1:0] tag;
    logic [ACT_W-1:0] action;
  } path_request_t;

  typedef struct packed {
    logic             transmitting;
    logic [CNT_W-1:0] aborted;
    logic [CNT_W-1:0] occupied;
    logic             found;
    logic [IDX_W-1:0] index;
    logic [3:0]       status;
  } path_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0]      cfg_paddr = '0;
  logic [DATA_W-1:0]      cfg_pwdata = '0;
  logic [DATA_W-1:0]      cfg_prdata;
  logic                   cfg_pready;

  demodulator_path_allocator_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #(PERIOD / 2) clk = ~clk;

  path_request_t request_backlog[$];
  path_result_t  result_due[$];
  logic [TAG_W-1:0] live_tags[$];

  logic [PWR_W-1:0] sens_cfg [NUM_SENS];
  logic [AP_W-1:0]  active_cfg;
  logic             lock_busy [PATHS];
  logic [TAG_W-1:0] lock_tag [PATHS];
  logic             tx_on;
  logic [CNT_W-1:0] busy_count;

  int  n_queued = 0;
  int  results_seen = 0;
  int  items_in = 0;
  int  errors = 0;
  int  cycles = 0;
  int  in_gap = 0;
  int  in_calm = 0;
  int  out_wait = 0;
  int  out_calm = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  in_taken = 1'b0;
  bit  out_taken = 1'b0;

  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  function automatic void free_pool();
    for (int i = 0; i < PATHS; i++) begin
      lock_busy[i] = 1'b0;
      lock_tag[i] = '0;
    end
    busy_count = '0;
  endfunction

  // Applies one request to the local pool and returns the result it causes.
  function automatic path_result_t allocate_path(input path_request_t r);
    path_result_t res;
    int lim;
    int sel;
    bit hit;
    res = '0;
    hit = 1'b0;
    lim = (active_cfg > PATHS) ? PATHS : int'(active_cfg);
    case (r.action)
      ACT_START_RX: begin
        if (tx_on) begin
          res.status = ST_DROP_TX;
        end else begin
          res.status = ST_DROP_NOPTH;
          for (int i = 0; i < lim && !hit; i++) begin
            if (!lock_busy[i]) begin
              hit = 1'b1;
              if (r.sf < SF_MIN) begin
                sel = 0;
              end else if (r.sf > SF_MAX) begin
                sel = NUM_SENS - 1;
              end else begin
                sel = int'(r.sf - SF_MIN);
              end
              if ($signed(r.power) < $signed(sens_cfg[sel])) begin
                res.status = ST_DROP_SENS;
              end else begin
                lock_busy[i] = 1'b1;
                lock_tag[i] = r.tag;
                busy_count++;
                res.status = ST_LOCKED;
                res.index = IDX_W'(i);
                res.found = 1'b1;
              end
            end
          end
        end
      end
      ACT_END_RX: begin
        res.status = (r.destroyed != 0) ? ST_INTERFERED : ST_RX_OK;
        for (int i = 0; i < lim && !hit; i++) begin
          if (lock_busy[i] && lock_tag[i] == r.tag) begin
            hit = 1'b1;
            lock_busy[i] = 1'b0;
            lock_tag[i] = '0;
            if (busy_count > 0) busy_count--;
            res.index = IDX_W'(i);
            res.found = 1'b1;
          end
        end
      end
      ACT_START_TX: begin
        for (int i = 0; i < PATHS; i++) begin
          if (lock_busy[i]) res.aborted++;
        end
        free_pool();
        tx_on = 1'b1;
        res.status = ST_TX_STARTED;
      end
      default: begin
        tx_on = 1'b0;
        res.status = ST_TX_DONE;
      end
    endcase
    res.occupied = busy_count;
    res.transmitting = tx_on;
    return res;
  endfunction

  // Request driver.
  always @(negedge clk) begin : feed
    logic                  nv;
    logic [IN_TDATA_W-1:0] nd;
    nv = in_tvalid && !in_taken;
    nd = in_tdata;
    if (!nv) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (request_backlog.size() > 0) begin
        nd = IN_TDATA_W'(request_backlog.pop_front());
        nv = 1'b1;
        in_gap = draw_wait(in_calm);
      end
    end
    in_tvalid <= nv;
    in_tdata <= nd;
  end

  // Result receiver.
  always @(negedge clk) begin
    if (out_taken) begin
      out_wait = draw_wait(out_calm);
    end else if (out_wait > 0) begin
      out_wait--;
    end
    out_tready <= rst_n && out_wait == 0 && hold_left == 0;
  end

  // One long hold-off on the result side so that the block backs up.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && items_in >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end
  end

  // Monitor, predictor and checker.
  always @(posedge clk) begin : watch
    path_request_t req;
    path_result_t  got;
    path_result_t  want;
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      in_taken = rst_n && in_tvalid && in_tready;
      out_taken = rst_n && out_tvalid && out_tready;
      if (out_taken) begin
        results_seen++;
        got = path_result_t'(out_tdata[$bits(path_result_t)-1:0]);
        if (result_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("mismatch: unexpected result %h", got);
        end else begin
          want = result_due.pop_front();
          if (got.status !== want.status || got.index !== want.index ||
              got.found !== want.found || got.occupied !== want.occupied ||
              got.aborted !== want.aborted ||
              got.transmitting !== want.transmitting) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: status %0d/%0d index %0d/%0d found %0d/%0d",
                       want.status, got.status, want.index, got.index,
                       want.found, got.found);
              $display("  occupied %0d/%0d aborted %0d/%0d transmitting %0d/%0d",
                       want.occupied, got.occupied, want.aborted, got.aborted,
                       want.transmitting, got.transmitting);
            end
          end
        end
      end
      if (in_taken) begin
        req = path_request_t'(in_tdata[$bits(path_request_t)-1:0]);
        result_due = {result_due, allocate_path(req)};
        items_in++;
      end
    end
  end

  task automatic send_item(input logic [ACT_W-1:0] action, input int tag, input int power,
                           input int sf, input int destroyed);
    path_request_t r;
    r.action = action;
    r.tag = TAG_W'(tag);
    r.power = PWR_W'(power);
    r.sf = SF_W'(sf);
    r.destroyed = DB_W'(destroyed);
    request_backlog = {request_backlog, r};
    n_queued++;
  endtask

  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == REG_ACTIVE_PATHS) begin
      active_cfg = val[AP_W-1:0];
      free_pool();
    end else begin
      sens_cfg[idx] = val[PWR_W-1:0];
    end
  endtask

  task automatic write_sens(input int lo, input int hi);
    for (int i = 0; i < NUM_SENS; i++) begin
      cfg_write(REG_SENS_SF7 + REG_IDX_W'(i), DATA_W'(lo + int'($urandom_range(0, hi - lo))));
    end
  endtask

  task automatic drain();
    while (results_seen < n_queued) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Mostly start and end of reception on tags that are live, some noise.
  task automatic queue_traffic(input int count);
    int pick;
    int k;
    int tag;
    int power;
    int sf;
    int destroyed;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      tag = $urandom_range(0, 65535);
      destroyed = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
      sf = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(7, 12);
      power = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) - 512
                                          : $urandom_range(0, 520) - 420;
      if (pick < 50) begin
        if ($urandom_range(0, 7) == 0) tag = $urandom_range(0, 3);
        live_tags = {live_tags, TAG_W'(tag)};
        if (live_tags.size() > 24) void'(live_tags.pop_front());
        send_item(ACT_START_RX, tag, power, sf, destroyed);
      end else if (pick < 88) begin
        if (live_tags.size() > 0 && $urandom_range(0, 4) != 0) begin
          k = $urandom_range(0, live_tags.size() - 1);
          tag = live_tags[k];
          live_tags.delete(k);
        end
        send_item(ACT_END_RX, tag, power, sf, destroyed);
      end else if (pick < 92) begin
        live_tags.delete();
        send_item(ACT_START_TX, tag, power, sf, destroyed);
      end else begin
        send_item(ACT_TX_DONE, tag, power, sf, destroyed);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_SENS; i++) sens_cfg[i] = SENS_RST[i];
    active_cfg = ACTIVE_PATHS_RST;
    tx_on = 1'b0;
    free_pool();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_item(ACT_TX_DONE, 0, 0, 7, 0);
    send_item(ACT_START_RX, 'hFFFF, -253, 7, 0);
    send_item(ACT_START_RX, 1, -254, 7, 0);
    send_item(ACT_START_RX, 2, -253, 0, 0);
    send_item(ACT_START_RX, 3, -279, 15, 0);
    send_item(ACT_START_RX, 4, -280, 12, 0);
    send_item(ACT_START_RX, 0, 511, 9, 0);
    send_item(ACT_START_RX, 5, -512, 10, 0);
    send_item(ACT_END_RX, 'hFFFF, 0, 7, 0);
    send_item(ACT_END_RX, 'h1234, 0, 7, 15);
    send_item(ACT_END_RX, 0, 0, 7, 12);
    send_item(ACT_START_TX, 0, 0, 7, 0);
    send_item(ACT_START_TX, 0, 0, 7, 0);
    send_item(ACT_START_RX, 6, 100, 8, 0);
    send_item(ACT_TX_DONE, 0, 0, 7, 0);
    for (int i = 0; i < 9; i++) send_item(ACT_START_RX, 10 + i, 100, 8 + (i % 4), 0);
    send_item(ACT_END_RX, 13, 0, 7, 7);
    drain();

    write_sens(-400, -400);
    cfg_write(REG_ACTIVE_PATHS, 15);
    queue_traffic(100);
    drain();

    write_sens(0, 0);
    cfg_write(REG_ACTIVE_PATHS, 1);
    queue_traffic(60);
    drain();

    cfg_write(REG_ACTIVE_PATHS, 0);
    queue_traffic(25);
    drain();

    write_sens(-400, 0);
    cfg_write(REG_ACTIVE_PATHS, 8);
    queue_traffic(170);
    drain();

    write_sens(-400, 0);
    cfg_write(REG_ACTIVE_PATHS, 3);
    queue_traffic(70);
    drain();

    write_sens(-300, -200);
    cfg_write(REG_ACTIVE_PATHS, 9);
    queue_traffic(60);
    drain();

    if (errors == 0 && result_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
